>>> rtl/rec_pkg.sv
// shared constants, types and codes for the read error corrected counter
`default_nettype none
package rec_pkg;

    // sequence geometry and store depth
    localparam int SEQ_LEN     = 50;
    localparam int MAX_ENTRIES = 1024;

    localparam int BASE_W   = 3;
    localparam int ROW_W    = SEQ_LEN * BASE_W;
    localparam int IDX_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LOADED_W = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W    = $clog2(SEQ_LEN + 1);

    // field widths fixed by the stream format
    localparam int OP_W     = 2;
    localparam int ENTRY_W  = 10;
    localparam int COUNT_W  = 48;
    localparam int WEIGHT_W = 16;
    localparam int NHITS_W  = 8;

    // share arithmetic
    localparam int TOTAL_W  = WEIGHT_W + LOADED_W;
    localparam int NUM_W    = (TOTAL_W > 2 * WEIGHT_W) ? TOTAL_W + 1 : 2 * WEIGHT_W + 1;
    localparam int DIV_CNT_W = $clog2(NUM_W);
    localparam logic [WEIGHT_W-1:0] NW_RESET = 16'd655;
    localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};

    // base codes
    localparam logic [BASE_W-1:0] BASE_T     = 3'd3;
    localparam logic [BASE_W-1:0] BASE_OTHER = 3'd4;

    // mismatch tally per entry, saturating at two
    localparam logic [1:0] DIFF_NONE = 2'd0;
    localparam logic [1:0] DIFF_ONE  = 2'd1;
    localparam logic [1:0] DIFF_MANY = 2'd2;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_READOUT = 2'd2;

    // result kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    typedef logic [BASE_W-1:0] base_t;
    typedef logic [ROW_W-1:0]  row_t;

    // status carried along the cell chain with one reference entry
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             dup;
        logic [IDX_W-1:0] idx;
        logic [1:0]       diffs;
        logic             letter;
    } cell_item_t;

endpackage
`default_nettype wire

>>> rtl/rec_cell.sv
// one compare cell: holds one read base and one load base, tallies mismatches
`default_nettype none
module rec_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  rd_we,
    input  wire                  ld_we,
    input  rec_pkg::base_t       wr_base,
    input  wire                  key_sel,
    input  rec_pkg::cell_item_t  item_in,
    input  rec_pkg::row_t        row_in,
    output rec_pkg::cell_item_t  item_out,
    output rec_pkg::row_t        row_out,
    output rec_pkg::base_t       ld_base
);
    import rec_pkg::*;

    base_t      rd_base_reg;
    base_t      ld_base_reg;
    cell_item_t item_reg;
    cell_item_t item_next;
    row_t       row_reg;
    base_t      key;
    base_t      ref_base;
    logic       mismatch;

    // compare the entry base at this position against the held key
    always_comb
    begin
        key       = key_sel ? ld_base_reg : rd_base_reg;
        ref_base  = row_in[BASE_W-1:0];
        mismatch  = (ref_base != key);
        item_next = item_in;
        if (item_in.valid && mismatch)
        begin
            if (item_in.diffs == DIFF_NONE)
            begin
                item_next.diffs  = DIFF_ONE;
                item_next.letter = (ref_base <= BASE_T);
            end
            else
            begin
                item_next.diffs = DIFF_MANY;
            end
        end
    end

    // item status, with reset on the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else
        begin
            item_reg <= item_next;
        end
    end

    // held bases and the remaining entry bases
    always_ff @(posedge clk)
    begin
        if (rd_we)
        begin
            rd_base_reg <= wr_base;
        end
        if (ld_we)
        begin
            ld_base_reg <= wr_base;
        end
        row_reg <= row_in >> BASE_W;
    end

    assign item_out = item_reg;
    assign row_out  = row_reg;
    assign ld_base  = ld_base_reg;

endmodule
`default_nettype wire

>>> rtl/rec_chain.sv
// row of compare cells, one per sequence position
`default_nettype none
module rec_chain (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        rd_we,
    input  wire                        ld_we,
    input  wire [rec_pkg::POS_W-1:0]   wr_pos,
    input  rec_pkg::base_t             wr_base,
    input  wire                        key_sel,
    input  rec_pkg::cell_item_t        item_in,
    input  rec_pkg::row_t              row_in,
    output rec_pkg::cell_item_t        item_out,
    output rec_pkg::row_t              ld_row
);
    import rec_pkg::*;

    cell_item_t items [SEQ_LEN+1];
    row_t       rows  [SEQ_LEN+1];

    assign items[0] = item_in;
    assign rows[0]  = row_in;

    // each cell takes the base written at its own position
    for (genvar i = 0; i < SEQ_LEN; i++)
    begin : g_cell
        rec_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .rd_we    (rd_we && (wr_pos == POS_W'(i))),
            .ld_we    (ld_we && (wr_pos == POS_W'(i))),
            .wr_base  (wr_base),
            .key_sel  (key_sel),
            .item_in  (items[i]),
            .row_in   (rows[i]),
            .item_out (items[i+1]),
            .row_out  (rows[i+1]),
            .ld_base  (ld_row[i*BASE_W +: BASE_W])
        );
    end

    assign item_out = items[SEQ_LEN];

endmodule
`default_nettype wire

>>> rtl/rec_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module rec_div (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire [rec_pkg::NUM_W-1:0]    dividend,
    input  wire [rec_pkg::TOTAL_W-1:0]  divisor,
    output logic                        done,
    output logic [rec_pkg::NUM_W-1:0]   quotient
);
    import rec_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TOTAL_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [TOTAL_W-1:0]   div_reg, div_next;
    logic [TOTAL_W:0]     rem_sh;
    logic                 fits;

    // shift in one dividend bit, subtract when it fits
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[NUM_W-1]};
        fits      = (rem_sh >= {1'b0, div_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? TOTAL_W'(rem_sh - {1'b0, div_reg}) : TOTAL_W'(rem_sh);
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

>>> rtl/read_error_corrected_counter.sv
// Top level: reference and counter stores, sequencer, cell chain and share divider.
// Completing an entry adds a duplicate scan of the stored entries, paced by the
// one-row-per-cycle reference store port, unless the store is still empty.
// Completing a read takes up to two scans through the cell chain plus two 33-step
// divisions.
// After reset the counter store is cleared, one entry per cycle, for all MAX_ENTRIES (1024)
// entries before the first transaction is accepted.
`default_nettype none
module read_error_corrected_counter (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // base[2:0], entry[12:3], zero[15:13]
    input  wire  [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata,   // entry_index[9:0], count[57:10], exact_hit[58],
                                   // neighbor_hits[66:59], weight_zero[67], zero[71:68]
    output logic        m_tuser,   // kind[0]
    input  wire         cfg_we,
    input  wire  [15:0] cfg_wdata  // neighbor_weight[15:0]
);
    import rec_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_LDWR, S_MUL, S_TOT, S_CHK,
        S_DIVX, S_DIVN, S_CWB, S_RD, S_OUT
    } state_t;

    typedef enum logic [1:0] {P_DUP, P_FIND, P_CREDIT} pass_t;

    state_t                state_reg, state_next;
    pass_t                 pass_reg, pass_next;
    logic [WEIGHT_W-1:0]   nw_reg, nw_next;
    logic [IDX_W-1:0]      clr_reg, clr_next;
    logic [LOADED_W-1:0]   loaded_reg, loaded_next;
    logic [POS_W-1:0]      load_pos_reg, load_pos_next;
    logic [POS_W-1:0]      read_pos_reg, read_pos_next;
    logic [LOADED_W-1:0]   iss_idx_reg, iss_idx_next;
    cell_item_t            iss_item_reg, iss_item_next;
    logic                  dup_found_reg, dup_found_next;
    logic                  exact_reg, exact_next;
    logic [IDX_W-1:0]      exact_entry_reg, exact_entry_next;
    logic [LOADED_W-1:0]   nbr_reg, nbr_next;
    logic                  wzero_reg, wzero_next;
    logic [TOTAL_W-1:0]    prod_reg, prod_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic [NUM_W-1:0]      sx_reg, sx_next;
    logic [NUM_W-1:0]      sn_reg, sn_next;
    logic                  s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0]      s1_idx_reg, s1_idx_next;
    logic [NUM_W-1:0]      s1_share_reg, s1_share_next;
    logic [IDX_W-1:0]      sel_entry_reg, sel_entry_next;
    logic [ENTRY_W-1:0]    ro_entry_reg, ro_entry_next;
    logic                  ro_ok_reg, ro_ok_next;
    logic                  kind_reg, kind_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [71:0]           m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    logic [ROW_W:0]        ref_mem [MAX_ENTRIES];
    logic [ROW_W:0]        ref_rdata_reg;
    logic [COUNT_W-1:0]    cnt_mem [MAX_ENTRIES];
    logic [COUNT_W-1:0]    cnt_rdata_reg;

    logic [OP_W-1:0]       op;
    base_t                 base_raw, base_in;
    logic [ENTRY_W-1:0]    entry_in;
    logic                  accept;
    logic                  rd_we, ld_we;
    logic [POS_W-1:0]      wr_pos;
    logic                  iss_valid;
    cell_item_t            chain_in, chain_out;
    row_t                  ld_row;
    logic                  hit_exact, hit_nbr;
    logic                  ref_we;
    logic [IDX_W-1:0]      cnt_raddr;
    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [COUNT_W-1:0]    cnt_wdata;
    logic [COUNT_W:0]      cnt_sum;
    logic                  div_start;
    logic [NUM_W-1:0]      div_num;
    logic                  div_done;
    logic [NUM_W-1:0]      div_quo;
    logic                  out_free;
    logic [NHITS_W-1:0]    nhits;

    // input transaction fields
    assign op       = s_tuser;
    assign base_raw = s_tdata[2:0];
    assign base_in  = (base_raw > BASE_OTHER) ? BASE_OTHER : base_raw;
    assign entry_in = s_tdata[12:3];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // base writes into the cell chain
    assign rd_we  = accept && (op == OP_READ);
    assign ld_we  = accept && (op == OP_LOAD) && (32'(loaded_reg) < 32'(MAX_ENTRIES));
    assign wr_pos = (op == OP_READ) ? read_pos_reg : load_pos_reg;

    // entry issue into the chain, the duplicate mark comes from the stored row
    assign iss_valid = (state_reg == S_SCAN) && (iss_idx_reg < loaded_reg);
    always_comb
    begin
        chain_in     = iss_item_reg;
        chain_in.dup = ref_rdata_reg[ROW_W];
    end

    rec_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_we    (rd_we),
        .ld_we    (ld_we),
        .wr_pos   (wr_pos),
        .wr_base  (base_in),
        .key_sel  (pass_reg == P_DUP),
        .item_in  (chain_in),
        .row_in   (ref_rdata_reg[ROW_W-1:0]),
        .item_out (chain_out),
        .ld_row   (ld_row)
    );

    assign hit_exact = chain_out.valid && !chain_out.dup && (chain_out.diffs == DIFF_NONE);
    assign hit_nbr   = chain_out.valid && !chain_out.dup && (chain_out.diffs == DIFF_ONE)
                       && chain_out.letter;

    // share divider
    assign div_num = (state_reg == S_CHK)
                     ? ((NUM_W'(1) << (2 * WEIGHT_W)) + NUM_W'(total_reg >> 1))
                     : ((NUM_W'(nw_reg) << WEIGHT_W) + NUM_W'(total_reg >> 1));

    rec_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // reference and counter store ports
    assign ref_we    = (state_reg == S_LDWR);
    assign cnt_raddr = (state_reg == S_SCAN) ? chain_out.idx : sel_entry_reg;
    assign cnt_sum   = {1'b0, cnt_rdata_reg} + (COUNT_W + 1)'(s1_share_reg);
    assign cnt_we    = (state_reg == S_CLEAR) || s1_valid_reg;
    assign cnt_waddr = (state_reg == S_CLEAR) ? clr_reg : s1_idx_reg;
    assign cnt_wdata = (state_reg == S_CLEAR) ? '0
                       : (cnt_sum[COUNT_W] ? COUNT_MAX : cnt_sum[COUNT_W-1:0]);

    assign out_free = !m_tvalid_reg || m_tready;
    assign nhits    = (32'(nbr_reg) > 32'd255) ? NHITS_W'(255) : NHITS_W'(nbr_reg);

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        pass_next        = pass_reg;
        nw_next          = cfg_we ? cfg_wdata : nw_reg;
        clr_next         = clr_reg;
        loaded_next      = loaded_reg;
        load_pos_next    = load_pos_reg;
        read_pos_next    = read_pos_reg;
        iss_idx_next     = iss_idx_reg;
        iss_item_next    = '0;
        dup_found_next   = dup_found_reg;
        exact_next       = exact_reg;
        exact_entry_next = exact_entry_reg;
        nbr_next         = nbr_reg;
        wzero_next       = wzero_reg;
        prod_next        = prod_reg;
        total_next       = total_reg;
        sx_next          = sx_reg;
        sn_next          = sn_reg;
        s1_valid_next    = 1'b0;
        s1_idx_next      = s1_idx_reg;
        s1_share_next    = s1_share_reg;
        sel_entry_next   = sel_entry_reg;
        ro_entry_next    = ro_entry_reg;
        ro_ok_next       = ro_ok_reg;
        kind_next        = kind_reg;
        m_tvalid_next    = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        div_start        = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(MAX_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_LOAD:
                        begin
                            if (ld_we)
                            begin
                                if (load_pos_reg == POS_W'(SEQ_LEN - 1))
                                begin
                                    load_pos_next  = '0;
                                    dup_found_next = 1'b0;
                                    pass_next      = P_DUP;
                                    iss_idx_next   = '0;
                                    state_next     = (loaded_reg == '0) ? S_LDWR : S_SCAN;
                                end
                                else
                                begin
                                    load_pos_next = load_pos_reg + 1'b1;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            if (read_pos_reg == POS_W'(SEQ_LEN - 1))
                            begin
                                read_pos_next = '0;
                                exact_next    = 1'b0;
                                nbr_next      = '0;
                                wzero_next    = 1'b0;
                                kind_next     = KIND_SUMMARY;
                                pass_next     = P_FIND;
                                iss_idx_next  = '0;
                                state_next    = (loaded_reg == '0) ? S_MUL : S_SCAN;
                            end
                            else
                            begin
                                read_pos_next = read_pos_reg + 1'b1;
                            end
                        end
                        OP_READOUT:
                        begin
                            kind_next      = KIND_READOUT;
                            ro_entry_next  = entry_in;
                            ro_ok_next     = (32'(entry_in) < 32'(MAX_ENTRIES));
                            sel_entry_next = IDX_W'(entry_in);
                            state_next     = S_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // issue one stored entry per cycle
                if (iss_valid)
                begin
                    iss_item_next.valid = 1'b1;
                    iss_item_next.last  = (iss_idx_reg == loaded_reg - 1'b1);
                    iss_item_next.idx   = IDX_W'(iss_idx_reg);
                    iss_idx_next        = iss_idx_reg + 1'b1;
                end
                // gather classified entries leaving the chain
                case (pass_reg)
                    P_DUP:
                    begin
                        if (hit_exact)
                        begin
                            dup_found_next = 1'b1;
                        end
                    end
                    P_FIND:
                    begin
                        if (hit_exact)
                        begin
                            exact_next       = 1'b1;
                            exact_entry_next = chain_out.idx;
                        end
                        if (hit_nbr)
                        begin
                            nbr_next = nbr_reg + 1'b1;
                        end
                    end
                    P_CREDIT:
                    begin
                        s1_valid_next = hit_exact || hit_nbr;
                        s1_idx_next   = chain_out.idx;
                        s1_share_next = hit_exact ? sx_reg : sn_reg;
                    end
                    default:
                    begin
                        s1_valid_next = 1'b0;
                    end
                endcase
                if (chain_out.valid && chain_out.last)
                begin
                    case (pass_reg)
                        P_DUP:    state_next = S_LDWR;
                        P_FIND:   state_next = S_MUL;
                        P_CREDIT: state_next = S_CWB;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end

            S_LDWR:
            begin
                loaded_next = loaded_reg + 1'b1;
                state_next  = S_IDLE;
            end

            S_MUL:
            begin
                prod_next  = TOTAL_W'(TOTAL_W'(nw_reg) * TOTAL_W'(nbr_reg));
                state_next = S_TOT;
            end

            S_TOT:
            begin
                total_next = prod_reg + (exact_reg ? (TOTAL_W'(1) << WEIGHT_W) : '0);
                state_next = S_CHK;
            end

            S_CHK:
            begin
                sel_entry_next = exact_entry_reg;
                if (!exact_reg && (nbr_reg == '0))
                begin
                    state_next = S_RD;
                end
                else if (total_reg == '0)
                begin
                    wzero_next = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVX;
                end
            end

            S_DIVX:
            begin
                if (div_done)
                begin
                    sx_next    = div_quo;
                    div_start  = 1'b1;
                    state_next = S_DIVN;
                end
            end

            S_DIVN:
            begin
                if (div_done)
                begin
                    sn_next      = div_quo;
                    pass_next    = P_CREDIT;
                    iss_idx_next = '0;
                    state_next   = S_SCAN;
                end
            end

            S_CWB:
            begin
                // last credit is written back in this cycle
                sel_entry_next = exact_entry_reg;
                state_next     = S_RD;
            end

            S_RD:
            begin
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = kind_reg;
                    if (kind_reg == KIND_READOUT)
                    begin
                        m_tdata_next = {4'b0, 1'b0, NHITS_W'(0), 1'b0,
                                        ro_ok_reg ? cnt_rdata_reg : COUNT_W'(0),
                                        ro_entry_reg};
                    end
                    else
                    begin
                        m_tdata_next = {4'b0, wzero_reg, nhits, exact_reg,
                                        exact_reg ? cnt_rdata_reg : COUNT_W'(0),
                                        exact_reg ? ENTRY_W'(exact_entry_reg) : ENTRY_W'(0)};
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pass_reg      <= P_FIND;
            nw_reg        <= NW_RESET;
            clr_reg       <= '0;
            loaded_reg    <= '0;
            load_pos_reg  <= '0;
            read_pos_reg  <= '0;
            iss_idx_reg   <= '0;
            iss_item_reg  <= '0;
            dup_found_reg <= 1'b0;
            exact_reg     <= 1'b0;
            nbr_reg       <= '0;
            wzero_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            kind_reg      <= KIND_SUMMARY;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            nw_reg        <= nw_next;
            clr_reg       <= clr_next;
            loaded_reg    <= loaded_next;
            load_pos_reg  <= load_pos_next;
            read_pos_reg  <= read_pos_next;
            iss_idx_reg   <= iss_idx_next;
            iss_item_reg  <= iss_item_next;
            dup_found_reg <= dup_found_next;
            exact_reg     <= exact_next;
            nbr_reg       <= nbr_next;
            wzero_reg     <= wzero_next;
            s1_valid_reg  <= s1_valid_next;
            kind_reg      <= kind_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        exact_entry_reg <= exact_entry_next;
        prod_reg        <= prod_next;
        total_reg       <= total_next;
        sx_reg          <= sx_next;
        sn_reg          <= sn_next;
        s1_idx_reg      <= s1_idx_next;
        s1_share_reg    <= s1_share_next;
        sel_entry_reg   <= sel_entry_next;
        ro_entry_reg    <= ro_entry_next;
        ro_ok_reg       <= ro_ok_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
    end

    // reference store: one row per entry plus its duplicate mark
    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[IDX_W'(loaded_reg)] <= {dup_found_reg, ld_row};
        end
        ref_rdata_reg <= ref_mem[IDX_W'(iss_idx_reg)];
    end

    // counter store
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata_reg <= cnt_mem[cnt_raddr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // credits are written back only during the credit scan or in the write-back state after it
    a_credit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ((state_reg == S_SCAN) || (state_reg == S_CWB)))
        else $error("counter credit outside credit scan");

    // the chain only delivers entries while a scan is running
    a_chain_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.valid |-> (state_reg == S_SCAN))
        else $error("chain output outside scan");

    // divider results only arrive while waiting for them
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == S_DIVX) || (state_reg == S_DIVN)))
        else $error("unexpected divider result");

    // the entry count never passes the store depth
    a_loaded_max: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(loaded_reg) <= 32'(MAX_ENTRIES)))
        else $error("entry count beyond store depth");

endmodule
`default_nettype wire
